// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/md5bh_pkg.sv =====
// ----------------------------------------------------------------------------
// md5bh_pkg
// Beat types, controller commands and MD5 round tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package md5bh_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned NUM_ROUNDS  = 64;

    typedef struct packed {
        logic [31:0] message_word;
        logic        first_of_message;
        logic        last_of_message;
    } t_md5_in;

    typedef struct packed {
        logic [31:0] digest_a;
        logic [31:0] digest_b;
        logic [31:0] digest_c;
        logic [31:0] digest_d;
    } t_md5_out;

    typedef struct packed {
        logic       wr_en;
        logic [3:0] wr_addr;
        logic       reload;
        logic       init_work;
        logic       init_first;
        logic       round_en;
        logic [5:0] round;
        logic       update;
        logic       emit;
    } t_md5_cmd;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = r[3:0];
        unique case (r[5:4])
            2'd0:    idx = r4;
            2'd1:    idx = 4'(r4 * 4'd5 + 4'd1);
            2'd2:    idx = 4'(r4 * 4'd3 + 4'd5);
            2'd3:    idx = 4'(r4 * 4'd7);
            default: idx = r4;
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/md5_block_hash.sv =====
// ----------------------------------------------------------------------------
// md5_block_hash
// MD5 engine over pre-padded 32-bit little-endian message words.
// ----------------------------------------------------------------------------
// Each input beat carries one word; sixteen beats fill a block, taken one per
// cycle. After the sixteenth word the single round unit runs the 64 rounds at
// one round per cycle, and the result is then folded into the chaining words.
// Input is not accepted during the rounds and the fold. A set first_of_message
// flag reloads the initial chaining values before its word; last_of_message
// is sampled on the sixteenth word, and that block's digest leaves as one
// output beat held in a register until taken, while the next message's words
// are already being accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module md5_block_hash (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire md5bh_pkg::t_md5_in  i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output md5bh_pkg::t_md5_out      o_data
);
    import md5bh_pkg::*;

    t_md5_cmd cmd;

    md5bh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_first (i_data.first_of_message),
        .i_last  (i_data.last_of_message),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    md5bh_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_data.message_word),
        .i_cmd   (cmd),
        .o_data  (o_data)
    );

    `ASSERT_SAME(a_no_accept_in_rounds, i_clk, i_rst_n, cmd.round_en, !o_ready, "ready during rounds")
    `ASSERT_NEXT(a_init_starts_rounds, i_clk, i_rst_n, cmd.init_work, cmd.round_en, "rounds did not start")
    `ASSERT_SAME(a_emit_when_free, i_clk, i_rst_n, cmd.emit, !o_valid || i_ready, "digest overwritten")
    `ASSERT_SAME(a_valid_from_emit, i_clk, i_rst_n, $rose(o_valid), $past(cmd.emit), "valid without digest")

endmodule

`default_nettype wire

// ===== rtl/md5bh_ctrl.sv =====
// ----------------------------------------------------------------------------
// md5bh_ctrl
// Sequencer: word fill, 64-round iteration, chaining update and digest beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5bh_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_first,
    input  wire logic                i_last,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output md5bh_pkg::t_md5_cmd      o_cmd
);
    import md5bh_pkg::*;

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [5:0] r_round, n_round;
    logic       r_last, n_last;
    logic       r_valid, n_valid;
    logic       accept;

    assign o_ready = (r_state == S_LOAD);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_round = r_round;
        n_last  = r_last;
        n_valid = r_valid && !i_ready;
        o_cmd   = '0;
        o_cmd.wr_addr = r_cnt;
        o_cmd.round   = r_round;
        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.reload = i_first;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'(BLOCK_WORDS - 1)) begin
                        o_cmd.init_work  = 1'b1;
                        o_cmd.init_first = i_first;
                        n_last  = i_last;
                        n_round = '0;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_cmd.round_en = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == 6'(NUM_ROUNDS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!(r_last && r_valid && !i_ready)) begin
                    o_cmd.update = 1'b1;
                    o_cmd.emit   = r_last;
                    if (r_last) begin
                        n_valid = 1'b1;
                    end
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_round <= '0;
            r_last  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_round <= n_round;
            r_last  <= n_last;
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/md5bh_dp.sv =====
// ----------------------------------------------------------------------------
// md5bh_dp
// Block buffer, chaining words, round unit and digest register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5bh_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [31:0]         i_word,
    input  wire md5bh_pkg::t_md5_cmd i_cmd,
    output md5bh_pkg::t_md5_out      o_data
);
    import md5bh_pkg::*;

    logic [31:0] r_buf [BLOCK_WORDS];
    logic [31:0] r_ca, r_cb, r_cc, r_cd;
    logic [31:0] r_a, r_b, r_c, r_d;
    t_md5_out    r_out;

    logic [31:0] f_val;
    logic [31:0] sum;
    logic [31:0] m_word;
    logic [31:0] sum_a, sum_b, sum_c, sum_d;

    assign m_word = r_buf[msg_index(i_cmd.round)];

    always_comb begin
        case (i_cmd.round[5:4])
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f_val = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f_val = r_b ^ r_c ^ r_d;
            default: f_val = r_c ^ (r_b | ~r_d);
        endcase
    end

    assign sum   = f_val + r_a + round_const(i_cmd.round) + m_word;
    assign sum_a = r_ca + r_a;
    assign sum_b = r_cb + r_b;
    assign sum_c = r_cc + r_c;
    assign sum_d = r_cd + r_d;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_buf[i_cmd.wr_addr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca <= INIT_A;
            r_cb <= INIT_B;
            r_cc <= INIT_C;
            r_cd <= INIT_D;
        end else if (i_cmd.reload) begin
            r_ca <= INIT_A;
            r_cb <= INIT_B;
            r_cc <= INIT_C;
            r_cd <= INIT_D;
        end else if (i_cmd.update) begin
            r_ca <= sum_a;
            r_cb <= sum_b;
            r_cc <= sum_c;
            r_cd <= sum_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_work) begin
            r_a <= i_cmd.init_first ? INIT_A : r_ca;
            r_b <= i_cmd.init_first ? INIT_B : r_cb;
            r_c <= i_cmd.init_first ? INIT_C : r_cc;
            r_d <= i_cmd.init_first ? INIT_D : r_cd;
        end else if (i_cmd.round_en) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rotl32(sum, rot_amount(i_cmd.round));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.digest_a <= sum_a;
            r_out.digest_b <= sum_b;
            r_out.digest_c <= sum_c;
            r_out.digest_d <= sum_d;
        end
    end

    assign o_data = r_out;

endmodule

`default_nettype wire
